// ----- hw/rtl/gsps_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid shortest path search package
// Shared types, constants and the controller to datapath command and status.
// ----------------------------------------------------------------------------
package gsps_pkg;

    localparam int GRID_DIM      = 8;
    localparam int CELLS         = 64;
    localparam int CELL_W        = 6;
    localparam int CNT_W         = 7;
    localparam int COST_W        = 10;
    localparam int SLOTS         = 9;
    localparam int SLOT_W        = 4;
    localparam int CENTRE_SLOT   = 4;
    localparam int MAX_TRACE     = CELLS - 1;
    localparam int STRAIGHT_COST = 10;
    localparam int DIAG_COST     = 14;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [2:0] cell_x;
        logic [2:0] cell_y;
        logic       cell_passable;
        logic [2:0] goal_x;
        logic [2:0] goal_y;
    } req_t;

    typedef struct packed {
        logic [2:0] path_x;
        logic [2:0] path_y;
        logic       found;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic [CELL_W-1:0] pos;
        logic [CELL_W-1:0] parent;
        logic [COST_W-1:0] cost;
    } entry_t;

    typedef enum logic [15:0] {
        S_IDLE      = 16'h0001,
        S_FIND_RD   = 16'h0002,
        S_FIND_EV   = 16'h0004,
        S_POP       = 16'h0008,
        S_SHIFT_CHK = 16'h0010,
        S_SHIFT_RD  = 16'h0020,
        S_SHIFT_WR  = 16'h0040,
        S_MATCH_CHK = 16'h0080,
        S_MATCH_RD  = 16'h0100,
        S_MATCH_EV  = 16'h0200,
        S_NB_RD     = 16'h0400,
        S_NB_EV     = 16'h0800,
        S_NEXT      = 16'h1000,
        S_NF        = 16'h2000,
        S_TRACE     = 16'h4000,
        S_TRACE_WT  = 16'h8000
    } state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic idx_clr;
        logic find_rd;
        logic find_ev;
        logic pop;
        logic shift_rd;
        logic shift_wr;
        logic hit_clr;
        logic match_rd;
        logic match_ev;
        logic slot_clr;
        logic nb_rd;
        logic nb_ev;
        logic trace_step;
        logic trace_end;
        logic trace_load;
        logic nf_emit;
    } cmd_t;

    typedef struct packed {
        logic is_search;
        logic idx_lt_cnt;
        logic idx_last;
        logic best_goal;
        logic slot_last;
        logic cnt_zero;
        logic trace_more;
    } status_t;

endpackage

// ----- hw/rtl/gsps_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gsps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hw/rtl/gsps_ctrl.sv -----
// ----------------------------------------------------------------------------
// Search controller
// State machine that sequences load, list scans, expansion and path trace.
// ----------------------------------------------------------------------------
module gsps_ctrl
    import gsps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (status.is_search)
                    begin
                        cmd.init   = 1'b1;
                        state_next = S_FIND_RD;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_FIND_RD:
            begin
                cmd.find_rd = 1'b1;
                state_next  = S_FIND_EV;
            end
            S_FIND_EV:
            begin
                cmd.find_ev = 1'b1;
                state_next  = status.idx_last ? S_POP : S_FIND_RD;
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = status.best_goal ? S_TRACE : S_SHIFT_CHK;
            end
            S_SHIFT_CHK:
            begin
                if (status.idx_lt_cnt)
                begin
                    state_next = S_SHIFT_RD;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    cmd.hit_clr = 1'b1;
                    state_next  = S_MATCH_CHK;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.shift_rd = 1'b1;
                state_next   = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_CHK;
            end
            S_MATCH_CHK:
            begin
                if (status.idx_lt_cnt)
                begin
                    state_next = S_MATCH_RD;
                end
                else
                begin
                    cmd.slot_clr = 1'b1;
                    state_next   = S_NB_RD;
                end
            end
            S_MATCH_RD:
            begin
                cmd.match_rd = 1'b1;
                state_next   = S_MATCH_EV;
            end
            S_MATCH_EV:
            begin
                cmd.match_ev = 1'b1;
                state_next   = S_MATCH_CHK;
            end
            S_NB_RD:
            begin
                cmd.nb_rd  = 1'b1;
                state_next = S_NB_EV;
            end
            S_NB_EV:
            begin
                cmd.nb_ev  = 1'b1;
                state_next = status.slot_last ? S_NEXT : S_NB_RD;
            end
            S_NEXT:
            begin
                if (status.cnt_zero)
                begin
                    state_next = S_NF;
                end
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = S_FIND_RD;
                end
            end
            S_NF:
            begin
                cmd.nf_emit = 1'b1;
                state_next  = S_IDLE;
            end
            S_TRACE:
            begin
                if (status.trace_more)
                begin
                    cmd.trace_step = 1'b1;
                    state_next     = S_TRACE_WT;
                end
                else
                begin
                    cmd.trace_end = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TRACE_WT:
            begin
                cmd.trace_load = 1'b1;
                state_next     = S_TRACE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/gsps_dp.sv -----
// ----------------------------------------------------------------------------
// Search datapath
// Grid, open list and parent memories, scan counters and the result register.
// ----------------------------------------------------------------------------
module gsps_dp
    import gsps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  req_t    req,
    input  cmd_t    cmd,
    output status_t status,
    output rsp_t    rsp,
    output logic    rsp_valid
);

    localparam int ENTRY_W = $bits(entry_t);

    logic [CELLS-1:0]  pv_reg;
    logic [CELLS-1:0]  closed_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  idx_reg;
    entry_t            best_reg;
    logic [CELL_W-1:0] best_idx_reg;
    logic [CELL_W-1:0] start_reg;
    logic [CELL_W-1:0] goal_reg;
    logic [SLOTS-1:0]  hit_reg;
    logic [CELL_W-1:0] midx_reg [SLOTS];
    logic [SLOT_W-1:0] slot_reg;
    logic [CELL_W-1:0] trc_reg;
    logic [CELL_W-1:0] k_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg;

    logic              load_ok;
    logic [CELL_W-1:0] load_cell;
    logic              pass_q;
    logic [CELL_W-1:0] parent_q;
    entry_t            open_q;
    logic              open_we;
    logic [CELL_W-1:0] open_waddr;
    entry_t            open_wdata;
    logic [CELL_W-1:0] open_raddr;
    logic [SLOTS-1:0]  nb_ing;
    logic [CELL_W-1:0] nb_cell [SLOTS];
    logic [CELL_W-1:0] cur_nb;
    logic [COST_W-1:0] nb_cost;
    logic              nb_ok;
    logic              nb_upd;
    logic              nb_app;
    logic [CNT_W-1:0]  idx_inc;

    // Neighbor cells of the expanded entry; slot s sits at dx = s%3-1, dy = s/3-1.
    for (genvar s = 0; s < SLOTS; s++)
    begin : g_nb
        localparam int SX = s % 3;
        localparam int SY = s / 3;
        logic [3:0] tx, ty;
        assign tx = {1'b0, best_reg.pos[2:0]} + 4'(SX);
        assign ty = {1'b0, best_reg.pos[5:3]} + 4'(SY);
        assign nb_ing[s] = (tx != 4'd0) && ((tx - 4'd1) < 4'(GRID_DIM))
                        && (ty != 4'd0) && ((ty - 4'd1) < 4'(GRID_DIM));
        assign nb_cell[s] = {3'(ty - 4'd1), 3'(tx - 4'd1)};
    end

    assign load_cell = {req.cell_y, req.cell_x};
    assign load_ok   = cmd.load && ({1'b0, req.cell_x} < 4'(GRID_DIM))
                    && ({1'b0, req.cell_y} < 4'(GRID_DIM));
    assign idx_inc   = idx_reg + CNT_W'(1);

    assign cur_nb  = nb_cell[slot_reg];
    assign nb_cost = best_reg.cost + (slot_reg[0] ? COST_W'(STRAIGHT_COST)
                                                  : COST_W'(DIAG_COST));
    assign nb_ok   = cmd.nb_ev && (slot_reg != SLOT_W'(CENTRE_SLOT)) && nb_ing[slot_reg]
                  && pv_reg[cur_nb] && pass_q && !closed_reg[cur_nb];
    assign nb_upd  = nb_ok && hit_reg[slot_reg] && (open_q.cost > nb_cost);
    assign nb_app  = nb_ok && !hit_reg[slot_reg] && (cnt_reg < CNT_W'(CELLS));

    always_comb
    begin
        open_we    = 1'b0;
        open_waddr = '0;
        open_wdata = open_q;
        if (cmd.init)
        begin
            open_we    = 1'b1;
            open_wdata = '{pos: load_cell, parent: load_cell, cost: '0};
        end
        else if (cmd.shift_wr)
        begin
            open_we    = 1'b1;
            open_waddr = idx_reg[CELL_W-1:0];
        end
        else if (nb_upd || nb_app)
        begin
            open_we    = 1'b1;
            open_waddr = nb_upd ? midx_reg[slot_reg] : cnt_reg[CELL_W-1:0];
            open_wdata = '{pos: cur_nb, parent: best_reg.pos, cost: nb_cost};
        end
    end

    always_comb
    begin
        open_raddr = idx_reg[CELL_W-1:0];
        if (cmd.shift_rd)
        begin
            open_raddr = idx_inc[CELL_W-1:0];
        end
        else if (cmd.nb_rd)
        begin
            open_raddr = midx_reg[slot_reg];
        end
    end

    gsps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_pass (
        .clk   (clk),
        .we    (load_ok),
        .waddr (load_cell),
        .wdata (req.cell_passable),
        .raddr (cur_nb),
        .rdata (pass_q)
    );

    gsps_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_parent (
        .clk   (clk),
        .we    (cmd.pop),
        .waddr (best_reg.pos),
        .wdata (best_reg.parent),
        .raddr (trc_reg),
        .rdata (parent_q)
    );

    gsps_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_open (
        .clk   (clk),
        .we    (open_we),
        .waddr (open_waddr),
        .wdata (open_wdata),
        .raddr (open_raddr),
        .rdata (open_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg        <= '0;
            closed_reg    <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= cmd.trace_step || cmd.trace_end || cmd.nf_emit;
            if (load_ok)
            begin
                pv_reg[load_cell] <= 1'b1;
            end
            if (cmd.init)
            begin
                closed_reg <= '0;
                cnt_reg    <= CNT_W'(1);
            end
            else if (cmd.pop)
            begin
                closed_reg[best_reg.pos] <= 1'b1;
                cnt_reg                  <= cnt_reg - CNT_W'(1);
            end
            else if (nb_app)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            start_reg <= load_cell;
            goal_reg  <= {req.goal_y, req.goal_x};
        end
        if (cmd.init || cmd.idx_clr)
        begin
            idx_reg <= '0;
        end
        else if (cmd.pop)
        begin
            idx_reg <= {1'b0, best_idx_reg};
        end
        else if (cmd.find_ev || cmd.shift_wr || cmd.match_ev)
        begin
            idx_reg <= idx_inc;
        end
        if (cmd.find_ev && ((idx_reg == '0) || (open_q.cost < best_reg.cost)))
        begin
            best_reg     <= open_q;
            best_idx_reg <= idx_reg[CELL_W-1:0];
        end
        if (cmd.hit_clr)
        begin
            hit_reg <= '0;
        end
        else if (cmd.match_ev)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (!hit_reg[s] && (open_q.pos == nb_cell[s]))
                begin
                    hit_reg[s]  <= 1'b1;
                    midx_reg[s] <= idx_reg[CELL_W-1:0];
                end
            end
        end
        if (cmd.slot_clr)
        begin
            slot_reg <= '0;
        end
        else if (cmd.nb_ev)
        begin
            slot_reg <= slot_reg + SLOT_W'(1);
        end
        if (cmd.pop)
        begin
            trc_reg <= goal_reg;
            k_reg   <= '0;
        end
        else if (cmd.trace_step)
        begin
            k_reg <= k_reg + CELL_W'(1);
        end
        else if (cmd.trace_load)
        begin
            trc_reg <= parent_q;
        end
        if (cmd.trace_step || cmd.trace_end)
        begin
            rsp_reg <= '{path_x: trc_reg[2:0], path_y: trc_reg[5:3], found: 1'b1,
                         last: cmd.trace_end};
        end
        else if (cmd.nf_emit)
        begin
            rsp_reg <= '{path_x: '0, path_y: '0, found: 1'b0, last: 1'b1};
        end
    end

    assign status.is_search  = (req.req_type == REQ_SEARCH);
    assign status.idx_lt_cnt = (idx_reg < cnt_reg);
    assign status.idx_last   = (idx_inc == cnt_reg);
    assign status.best_goal  = (best_reg.pos == goal_reg);
    assign status.slot_last  = (slot_reg == SLOT_W'(SLOTS - 1));
    assign status.cnt_zero   = (cnt_reg == '0);
    assign status.trace_more = (k_reg != CELL_W'(MAX_TRACE)) && (trc_reg != start_reg);

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// ----- hw/rtl/grid_shortest_path_search.sv -----
// ----------------------------------------------------------------------------
// Grid shortest path search
// Best-first search over an 8-connected square grid with path readout.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A load word writes one
// cell's passable bit in that cycle and leaves busy low, so loads can follow
// every cycle. A search word raises busy until its last result has been put
// out; results appear one per strobe on rsp_valid, goal cell first, and the
// receiver must take each in the cycle it is shown because nothing holds them.
// A search runs one expansion per closed cell. Each expansion scans the open list
// for its minimum entry, removes that entry while keeping the order of the rest,
// and looks up the neighbors of the expanded cell on the list, each pass going
// through the single read port of the open list memory, and then visits each of
// the nine neighbor slots. The path readout then steps from the goal through the
// parent memory, one path cell per result word, and a failed search ends with one
// not-found word. Results of one search never interleave with the next, since a
// new word is only taken once busy has dropped.
// ----------------------------------------------------------------------------
module grid_shortest_path_search
    import gsps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output rsp_t rsp,
    output logic rsp_valid
);

    cmd_t    cmd;
    status_t status;

    // The controller only sequences; every store and counter lives in the datapath.
    gsps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    gsps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

`ifndef SYNTHESIS
    // The final word of a search is never followed directly by another result.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.last |=> !rsp_valid)
        else $error("result right after the final word");

    // An accepted search word always occupies the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (req.req_type == REQ_SEARCH) |=> busy)
        else $error("search word did not raise busy");

    // A not-found word is the only word of its search and carries cell zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.last && (rsp.path_x == '0) && (rsp.path_y == '0))
        else $error("malformed not-found word");

    // More path words are still coming, so the block must stay busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> busy)
        else $error("block went idle in the middle of a path");
`endif

endmodule
